### design/lfpr_pkg.sv
// Shared constants and types for the length-framed packet receiver.
package lfpr_pkg;

  localparam int FRAME_DEPTH = 20;              // frame store entries
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 8;
  localparam int CNT_W       = LEN_W + 1;       // length plus overhead
  localparam int POS_W       = $clog2(FRAME_DEPTH);
  localparam int OUT_POS_W   = 5;               // width of byte_position
  localparam int QDEPTH      = 4;               // command queue entries
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [POS_W-1:0] SYNC1_SLOT  = POS_W'(0);
  localparam logic [POS_W-1:0] SYNC2_SLOT  = POS_W'(1);
  localparam logic [POS_W-1:0] LENGTH_SLOT = POS_W'(7);
  localparam logic [CNT_W-1:0] FRAME_OVERHEAD = CNT_W'(10);
  localparam logic [CNT_W-1:0] DEPTH_CNT      = CNT_W'(FRAME_DEPTH);

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hFF;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hCC;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

  // one command per accepted item: store the byte, optionally emit frame
  typedef struct packed {
    logic              emit;   // frame complete, addr is last position
    logic [POS_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### design/lfpr_front.sv
// Front end: accepts bytes, tracks frame position and issues store/emit commands.
module lfpr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lfpr_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic [lfpr_pkg::BYTE_W-1:0]   sync_first,
  input  logic [lfpr_pkg::BYTE_W-1:0]   sync_second,
  input  lfpr_pkg::q_stat_t             q_stat,
  output logic                          push,
  output lfpr_pkg::cmd_t                cmd
);

  logic [lfpr_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [lfpr_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [lfpr_pkg::POS_W-1:0] pos_inc;
  logic [lfpr_pkg::CNT_W-1:0] count;
  logic [lfpr_pkg::CNT_W-1:0] new_count;
  logic                       emit;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;
  assign pos_inc  = pos_r + lfpr_pkg::POS_W'(1);
  assign count     = lfpr_pkg::CNT_W'(len_r) + lfpr_pkg::FRAME_OVERHEAD;
  assign new_count = lfpr_pkg::CNT_W'(in_rx_byte) + lfpr_pkg::FRAME_OVERHEAD;

  always_comb begin
    pos_nxt = pos_r;
    len_nxt = len_r;
    emit    = 1'b0;
    if (push) begin
      priority if (pos_r == lfpr_pkg::SYNC1_SLOT) begin
        pos_nxt = (in_rx_byte == sync_first) ? pos_inc : '0;
      end else if (pos_r == lfpr_pkg::SYNC2_SLOT) begin
        pos_nxt = (in_rx_byte == sync_second) ? pos_inc : '0;
      end else if (pos_r == lfpr_pkg::LENGTH_SLOT) begin
        len_nxt = in_rx_byte;
        // oversize frame: drop it here
        pos_nxt = (new_count > lfpr_pkg::DEPTH_CNT) ? '0 : pos_inc;
      end else if (pos_r > lfpr_pkg::LENGTH_SLOT &&
                   lfpr_pkg::CNT_W'(pos_r) + lfpr_pkg::CNT_W'(1) == count) begin
        emit    = 1'b1;
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_comb begin
    cmd.emit = emit;
    cmd.addr = pos_r;
    cmd.data = in_rx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

### design/lfpr_cmd_fifo.sv
// Short command queue between the front end and the back end.
module lfpr_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lfpr_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output lfpr_pkg::cmd_t    head_cmd,
  output lfpr_pkg::q_stat_t q_stat
);

  lfpr_pkg::cmd_t              mem_r [lfpr_pkg::QDEPTH];
  logic [lfpr_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [lfpr_pkg::QPTR_W:0]   cnt_r;

  assign q_stat.full  = (cnt_r == (lfpr_pkg::QPTR_W+1)'(lfpr_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_cmd     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + lfpr_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + lfpr_pkg::QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (lfpr_pkg::QPTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (lfpr_pkg::QPTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### design/lfpr_back.sv
// Back end: executes commands, owns the frame store and streams out frames.
module lfpr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lfpr_pkg::cmd_t                    head_cmd,
  input  lfpr_pkg::q_stat_t                 q_stat,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lfpr_pkg::BYTE_W-1:0]       out_frame_byte,
  output logic [lfpr_pkg::OUT_POS_W-1:0]    out_byte_position,
  output logic                              out_frame_end
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t                      state_r, state_nxt;
  logic [lfpr_pkg::BYTE_W-1:0] store_r [lfpr_pkg::FRAME_DEPTH];
  logic [lfpr_pkg::POS_W-1:0]  k_r, k_nxt;
  logic [lfpr_pkg::POS_W-1:0]  last_r, last_nxt;
  logic                        out_free;
  logic                        load;
  logic                        ovld_r, ovld_nxt;
  logic [lfpr_pkg::BYTE_W-1:0] obyte_r;
  logic [lfpr_pkg::OUT_POS_W-1:0] opos_r;
  logic                        oend_r;

  assign out_free = !ovld_r || !out_stall;
  assign pop      = (state_r == S_IDLE) && !q_stat.empty;
  assign load     = (state_r == S_EMIT) && out_free;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    last_nxt  = last_r;
    ovld_nxt  = ovld_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (pop && head_cmd.emit) begin
          state_nxt = S_EMIT;
          k_nxt     = '0;
          last_nxt  = head_cmd.addr;
        end
      end
      S_EMIT: begin
        if (load) begin
          ovld_nxt = 1'b1;
          if (k_r == last_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + lfpr_pkg::POS_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      store_r[head_cmd.addr] <= head_cmd.data;
    end
    if (load) begin
      obyte_r <= store_r[k_r];
      opos_r  <= lfpr_pkg::OUT_POS_W'(k_r);
      oend_r  <= (k_r == last_r);
    end
    k_r    <= k_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign out_valid         = ovld_r;
  assign out_frame_byte    = obyte_r;
  assign out_byte_position = opos_r;
  assign out_frame_end     = oend_r;

endmodule

### design/length_framed_packet_receiver_core.sv
// Top level of the length-framed packet receiver: config registers and wiring.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in_     | input     | in_valid/in_stall  | in_rx_byte[7:0]
//  out_    | output    | out_valid/out_stall| out_frame_byte, out_byte_position, out_frame_end
//  cfg_    | input     | cfg_we             | cfg_index, cfg_wdata (0 sync_first, 1 sync_second)
//
// The front end takes one byte per cycle while its command queue (4 deep) has room.
// A byte that completes a frame makes the back end stream length+10 items, one per
// cycle while out_stall is low, so a full frame is 10 to 20 items long.
// Reset (rst_n, synchronous) clears position, length, queue and output valid; the
// frame store is not cleared, every emitted byte is written in its own frame.
// in_stall rises only when the command queue is full; out_stall holds the output item.
module length_framed_packet_receiver_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input byte channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lfpr_pkg::BYTE_W-1:0]         in_rx_byte,
  // frame byte channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lfpr_pkg::BYTE_W-1:0]         out_frame_byte,
  output logic [lfpr_pkg::OUT_POS_W-1:0]      out_byte_position,
  output logic                                out_frame_end,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [lfpr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfpr_pkg::BYTE_W-1:0]         cfg_wdata
);

  logic [lfpr_pkg::BYTE_W-1:0] sync_first_r;
  logic [lfpr_pkg::BYTE_W-1:0] sync_second_r;

  logic              push;
  logic              pop;
  lfpr_pkg::cmd_t    push_cmd;
  lfpr_pkg::cmd_t    head_cmd;
  lfpr_pkg::q_stat_t q_stat;

  // sync registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= lfpr_pkg::SYNC_FIRST_RST;
      sync_second_r <= lfpr_pkg::SYNC_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfpr_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        lfpr_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: header checks, length capture, frame completion
  lfpr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .q_stat      (q_stat),
    .push        (push),
    .cmd         (push_cmd)
  );

  // store/emit commands wait here while a frame is being streamed
  lfpr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  // back: frame store writes and frame streaming
  lfpr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_cmd          (head_cmd),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_byte_position (out_byte_position),
    .out_frame_end     (out_frame_end)
  );

endmodule

### design/lfpr_checker.sv
// Port-level checks for the packet receiver, bound to the top level.
module lfpr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [lfpr_pkg::BYTE_W-1:0]    out_frame_byte,
  input logic [lfpr_pkg::OUT_POS_W-1:0] out_byte_position,
  input logic                           out_frame_end
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte) &&
      $stable(out_byte_position) && $stable(out_frame_end))
    else $error("stalled output item changed");

  // reset leaves no item on the output
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a frame is never shorter than ten bytes
  a_min_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_byte_position >= lfpr_pkg::OUT_POS_W'(9))
    else $error("frame end before position 9");

  // frame bytes stream back to back with rising positions
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_frame_end |=> out_valid &&
      out_byte_position == lfpr_pkg::OUT_POS_W'($past(out_byte_position) + 1'b1))
    else $error("frame stream broken");

endmodule

bind length_framed_packet_receiver_core lfpr_checker u_lfpr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_frame_byte    (out_frame_byte),
  .out_byte_position (out_byte_position),
  .out_frame_end     (out_frame_end)
);
